// ===== design/ssf_pkg.sv =====
// shared types and constants for the shortest subtour finder
// no dependencies; imported by every design file
package ssf_pkg;

  localparam int ID_W      = 6;
  localparam int LEN_W     = 7;
  localparam int VALUE_W   = 16;
  localparam int IN_DEPTH  = 4;
  localparam int IN_PTR_W  = 2;
  localparam int IN_CNT_W  = 3;
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = 1;
  localparam int OUT_CNT_W = 2;

  localparam logic [VALUE_W-1:0] HALF_Q2_14       = 16'd8192;
  localparam logic [LEN_W-1:0]   NODE_COUNT_RESET = 7'd32;
  localparam logic [LEN_W-1:0]   NODE_COUNT_MIN   = 7'd2;

  typedef struct packed {
    logic [ID_W-1:0] row;
    logic [ID_W-1:0] col;
    logic            sel;
    logic            in_range;
    logic            last;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]  node_id;
    logic [LEN_W-1:0] tour_length;
    logic             covers_all;
    logic             last_node;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } walk_state_t;

endpackage

// ===== design/ssf_front.sv =====
// front end: accepts matrix entries, classifies them and queues them
// depends on ssf_pkg
module ssf_front import ssf_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [ID_W-1:0]    row_index,
  input  logic [ID_W-1:0]    col_index,
  input  logic [VALUE_W-1:0] edge_value,
  input  logic               last_entry,
  output logic               entry_valid,
  output entry_t             entry,
  input  logic               entry_take
);

  entry_t                entries [IN_DEPTH];
  logic [IN_PTR_W-1:0]   wr_ptr;
  logic [IN_PTR_W-1:0]   rd_ptr;
  logic [IN_CNT_W-1:0]   count;
  logic                  push_ok;
  logic                  take_ok;
  entry_t                classified;

  always_comb begin
    classified.row      = row_index;
    classified.col      = col_index;
    classified.sel      = (edge_value > HALF_Q2_14);
    classified.in_range = ({1'b0, row_index} < LEN_W'(MAX_NODES))
                       && ({1'b0, col_index} < LEN_W'(MAX_NODES));
    classified.last     = last_entry;
  end

  assign full        = (count == IN_CNT_W'(IN_DEPTH));
  assign entry_valid = (count != '0);
  assign entry       = entries[rd_ptr];
  assign push_ok     = push && !full;
  assign take_ok     = entry_take && entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !take_ok) begin
        count <= count + 1'b1;
      end else if (!push_ok && take_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= classified;
    end
  end

endmodule

// ===== design/ssf_walker.sv =====
// back end: adjacency store, walk sequencer, walk buffer and result read-out
// depends on ssf_pkg
module ssf_walker import ssf_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [LEN_W-1:0]     node_count,
  input  logic                 entry_valid,
  input  entry_t               entry,
  output logic                 entry_take,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_push,
  output result_t              res
);

  localparam int IDX_W = $clog2(MAX_NODES);

  function automatic logic [IDX_W-1:0] lowest(input logic [MAX_NODES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  walk_state_t state, state_next;

  logic [MAX_NODES-1:0] adj [MAX_NODES];
  logic [MAX_NODES-1:0] adj_valid;
  logic [IDX_W-1:0]     walk_buf [MAX_NODES];

  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] node_mask;
  logic [MAX_NODES-1:0] mask_next;
  logic [IDX_W-1:0]     cur;
  logic [LEN_W-1:0]     wstart;
  logic [LEN_W-1:0]     wlen;
  logic [LEN_W-1:0]     best_start;
  logic [LEN_W-1:0]     best_len;
  logic [LEN_W-1:0]     n_use;
  logic [LEN_W-1:0]     n_sat;
  logic [LEN_W-1:0]     emit_k;

  logic [MAX_NODES-1:0] vis_new;
  logic [MAX_NODES-1:0] row_data;
  logic [MAX_NODES-1:0] cand;
  logic [MAX_NODES-1:0] free_nodes;
  logic [LEN_W-1:0]     len_new;
  logic [LEN_W-1:0]     wstart_new;
  logic [LEN_W-1:0]     pos;
  logic [LEN_W-1:0]     rd_addr;
  logic [OUT_CNT_W:0]   occupancy;
  logic                 can_issue;
  logic                 emit_last;
  logic                 walk_done;
  logic                 start;

  logic                 rd_pending;
  logic [IDX_W-1:0]     rd_data;
  logic [LEN_W-1:0]     rd_len;
  logic                 rd_covers;
  logic                 rd_last;

  logic [IDX_W-1:0]     wr_row;
  logic [IDX_W-1:0]     wr_col;

  // node count in use, saturated into the legal range
  always_comb begin
    priority if (node_count < NODE_COUNT_MIN) begin
      n_sat = NODE_COUNT_MIN;
    end else if (node_count > LEN_W'(MAX_NODES)) begin
      n_sat = LEN_W'(MAX_NODES);
    end else begin
      n_sat = node_count;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask_next[i] = (LEN_W'(i) < n_sat);
    end
  end

  // one walk step per cycle
  assign vis_new    = visited | (MAX_NODES'(1) << cur);
  assign row_data   = adj_valid[cur] ? adj[cur] : '0;
  assign cand       = row_data & ~vis_new & node_mask;
  assign free_nodes = ~vis_new & node_mask;
  assign len_new    = wlen + 1'b1;
  assign wstart_new = wstart + len_new;
  assign pos        = wstart + wlen;
  assign walk_done  = (state == ST_WALK) && (cand == '0) && (free_nodes == '0);

  // read-out with credit against the result queue
  assign occupancy  = (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(rd_pending);
  assign can_issue  = (state == ST_EMIT) && (occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign emit_last  = ((emit_k + 1'b1) == best_len);
  assign rd_addr    = best_start + emit_k;

  assign entry_take = (state == ST_IDLE) && entry_valid;
  assign start      = entry_take && entry.last;

  assign wr_row = entry.row[IDX_W-1:0];
  assign wr_col = entry.col[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_issue && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // row valid bits: a row not yet written this round reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid  <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= can_issue;
      if (entry_take && entry.in_range) begin
        adj_valid[wr_row] <= 1'b1;
      end
      if (walk_done) begin
        adj_valid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_take && entry.in_range) begin
      if (adj_valid[wr_row]) begin
        adj[wr_row][wr_col] <= entry.sel;
      end else begin
        adj[wr_row] <= entry.sel ? (MAX_NODES'(1) << wr_col) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      visited    <= '0;
      cur        <= '0;
      wstart     <= '0;
      wlen       <= '0;
      best_len   <= n_sat + 1'b1;
      best_start <= '0;
      n_use      <= n_sat;
      node_mask  <= mask_next;
      emit_k     <= '0;
    end else if (state == ST_WALK) begin
      visited <= vis_new;
      if (cand != '0) begin
        cur  <= lowest(cand);
        wlen <= len_new;
      end else begin
        if (len_new < best_len) begin
          best_len   <= len_new;
          best_start <= wstart;
        end
        cur    <= lowest(free_nodes);
        wlen   <= '0;
        wstart <= wstart_new;
      end
    end else if (can_issue) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WALK) begin
      walk_buf[pos[IDX_W-1:0]] <= cur;
    end
    if (can_issue) begin
      rd_data   <= walk_buf[rd_addr[IDX_W-1:0]];
      rd_len    <= best_len;
      rd_covers <= (best_len == n_use);
      rd_last   <= emit_last;
    end
  end

  assign res_push        = rd_pending;
  assign res.node_id     = ID_W'(rd_data);
  assign res.tour_length = rd_len;
  assign res.covers_all  = rd_covers;
  assign res.last_node   = rd_last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_cur_unvisited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !visited[cur])
    else $error("walk stepped onto a visited node");

  a_store_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (adj_valid == '0))
    else $error("adjacency not cleared before read-out");

  a_best_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((best_len != '0) && (best_len <= n_use)))
    else $error("shortest walk length out of range");

endmodule

// ===== design/ssf_outq.sv =====
// result queue between the walker and the output ports
// depends on ssf_pkg
module ssf_outq import ssf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_push,
  input  result_t              res,
  input  logic                 pop,
  output logic                 empty,
  output result_t              head,
  output logic [OUT_CNT_W-1:0] count
);

  result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 pop_ok;

  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (res_push && !pop_ok) begin
        count <= count + 1'b1;
      end else if (!res_push && pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res;
    end
  end

endmodule

// ===== design/shortest_subtour_finder_core.sv =====
// top level of the shortest subtour finder: node count register and block wiring
// depends on ssf_pkg, ssf_front, ssf_walker, ssf_outq
//
// channel   direction  handshake          payload
// entries   in         push / full        row_index, col_index, edge_value, last_entry
// results   out        pop / empty        node_id, tour_length, covers_all, last_node
// config    in         cfg_we             cfg_wdata (node count)
//
// matrix entries load one per cycle through a four-deep entry queue
// a last entry runs the walks at one node per cycle,
// then reads out the shortest walk from the walk buffer while the result queue has room
// entries keep queuing during a walk until the entry queue fills
// synchronous reset; the adjacency store is cleared by row valid bits, no clearing pass
module shortest_subtour_finder_core import ssf_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [ID_W-1:0]    row_index,
  input  logic [ID_W-1:0]    col_index,
  input  logic [VALUE_W-1:0] edge_value,
  input  logic               last_entry,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_wdata,
  output logic               empty,
  input  logic               pop,
  output logic [ID_W-1:0]    node_id,
  output logic [LEN_W-1:0]   tour_length,
  output logic               covers_all,
  output logic               last_node
);

  logic [LEN_W-1:0]     node_count;
  logic                 entry_valid;
  entry_t               entry;
  logic                 entry_take;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 res_push;
  result_t              res;
  result_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  ssf_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .row_index   (row_index),
    .col_index   (col_index),
    .edge_value  (edge_value),
    .last_entry  (last_entry),
    .entry_valid (entry_valid),
    .entry       (entry),
    .entry_take  (entry_take)
  );

  ssf_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .node_count  (node_count),
    .entry_valid (entry_valid),
    .entry       (entry),
    .entry_take  (entry_take),
    .out_count   (out_count),
    .res_push    (res_push),
    .res         (res)
  );

  ssf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .pop      (pop),
    .empty    (empty),
    .head     (head),
    .count    (out_count)
  );

  assign node_id     = head.node_id;
  assign tour_length = head.tour_length;
  assign covers_all  = head.covers_all;
  assign last_node   = head.last_node;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for shortest_subtour_finder_core
// random edge matrices with a built-in walk predictor; depends on ssf_pkg and the design files
module tb_top;
  import ssf_pkg::*;

  localparam int MAX_NODES     = 32;
  localparam int RANDOM_ITEMS  = 360;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum logic [1:0] {
    ACT_ENTRY,
    ACT_NODE_COUNT,
    ACT_QUIESCE
  } action_kind_t;

  typedef struct {
    action_kind_t     kind;
    logic [ID_W-1:0]  row;
    logic [ID_W-1:0]  col;
    logic [VALUE_W-1:0] value;
    logic             last;
    logic [LEN_W-1:0] count;
  } action_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [ID_W-1:0] row_index = '0;
  logic [ID_W-1:0] col_index = '0;
  logic [VALUE_W-1:0] edge_value = '0;
  logic last_entry = 1'b0;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ID_W-1:0] node_id;
  logic [LEN_W-1:0] tour_length;
  logic covers_all;
  logic last_node;

  action_t pending_actions[$];
  result_t walk_results_q[$];
  logic [MAX_NODES-1:0] edge_rows [MAX_NODES];
  logic [LEN_W-1:0] node_count_reg = NODE_COUNT_RESET;

  int loaded_entries = 0;
  int entries_taken = 0;
  int results_seen = 0;
  int settings_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic entry_taken = 1'b0;
  bit quiescing = 0;
  int settle = 0;
  int send_gap = 0;
  int out_stall = 0;
  bit in_burst = 0;
  bit out_burst = 0;

  shortest_subtour_finder_core #(.MAX_NODES(MAX_NODES)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .row_index(row_index), .col_index(col_index), .edge_value(edge_value),
    .last_entry(last_entry), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .empty(empty), .pop(pop), .node_id(node_id), .tour_length(tour_length),
    .covers_all(covers_all), .last_node(last_node)
  );

  always #10 clk = ~clk;

  function automatic int active_nodes(input logic [LEN_W-1:0] count);
    if (count < 2) return 2;
    if (count > MAX_NODES) return MAX_NODES;
    return int'(count);
  endfunction

  function automatic int first_set(input logic [MAX_NODES-1:0] bits);
    for (int i = 0; i < MAX_NODES - 1; i++) if (bits[i]) return i;
    return MAX_NODES - 1;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // loads one matrix entry; a last entry walks the graph and queues the shortest walk
  task automatic apply_entry(input logic [ID_W-1:0] r, input logic [ID_W-1:0] c,
                             input logic [VALUE_W-1:0] v, input logic lst);
    int n, cur, wstart, wlen, blen, bstart;
    bit done;
    logic [MAX_NODES-1:0] mask, visited, cand;
    logic [ID_W-1:0] walk_nodes [MAX_NODES];
    result_t res;
    if (r < MAX_NODES && c < MAX_NODES) edge_rows[r][c] = (v > HALF_Q2_14);
    if (lst) begin
      n = active_nodes(node_count_reg);
      mask = (n >= MAX_NODES) ? '1 : ((MAX_NODES)'(1) << n) - 1;
      visited = '0;
      wstart = 0;
      blen = n + 1;
      bstart = 0;
      while (wstart < n && (~visited & mask) != '0) begin
        cur = first_set(~visited & mask);
        wlen = 0;
        done = 0;
        while (!done) begin
          walk_nodes[wstart + wlen] = ID_W'(cur);
          visited[cur] = 1'b1;
          wlen++;
          cand = edge_rows[cur] & ~visited & mask;
          if (cand == '0) done = 1;
          else cur = first_set(cand);
        end
        if (wlen < blen) begin
          blen = wlen;
          bstart = wstart;
        end
        wstart += wlen;
      end
      if (blen > n) blen = n;
      for (int k = 0; k < blen; k++) begin
        res.node_id = walk_nodes[bstart + k];
        res.tour_length = LEN_W'(blen);
        res.covers_all = (blen == n);
        res.last_node = (k == blen - 1);
        walk_results_q.push_back(res);
      end
      for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
    end
  endtask

  task automatic add_entry(input int r, input int c, input int v, input bit lst);
    action_t a;
    a.kind = ACT_ENTRY;
    a.row = ID_W'(r);
    a.col = ID_W'(c);
    a.value = VALUE_W'(v);
    a.last = lst;
    a.count = '0;
    pending_actions.push_back(a);
    if (r < MAX_NODES && c < MAX_NODES) loaded_entries++;
  endtask

  // the block must be idle before the register changes
  task automatic add_node_count(input int count);
    action_t a;
    a.kind = ACT_QUIESCE;
    a.row = '0;
    a.col = '0;
    a.value = '0;
    a.last = 1'b0;
    a.count = '0;
    pending_actions.push_back(a);
    a.kind = ACT_NODE_COUNT;
    a.count = LEN_W'(count);
    pending_actions.push_back(a);
  endtask

  function automatic int sel_value();
    return $urandom_range(HALF_Q2_14 + 1, 65535);
  endfunction

  function automatic int unsel_value();
    return $urandom_range(0, HALF_Q2_14);
  endfunction

  // one graph: mostly disjoint cycles over a shuffled node order, some noise
  task automatic add_graph(input int n);
    int order [MAX_NODES];
    int i, j, t, pos, run, style, row;
    bit whole;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    style = $urandom_range(0, 9);
    if (style >= 8) begin
      repeat ($urandom_range(1, 6))
        add_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535), 0);
    end else if (n > 12 && $urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(2, 8))
        add_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1), sel_value(), 0);
    end else begin
      whole = ($urandom_range(0, 3) == 0);
      pos = 0;
      while (pos < n) begin
        run = whole ? n - pos : $urandom_range(1, (n - pos) < 6 ? (n - pos) : 6);
        if (run > 1) begin
          for (i = 0; i < run; i++) begin
            add_entry(order[pos + i], order[pos + (i + 1) % run], sel_value(), 0);
            if ($urandom_range(0, 1) == 0)
              add_entry(order[pos + (i + 1) % run], order[pos + i], sel_value(), 0);
          end
        end
        pos += run;
      end
    end
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: add_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1), unsel_value(), 0);
        1: add_entry($urandom_range(MAX_NODES, 63), $urandom_range(0, 63),
                     $urandom_range(0, 65535), 0);
        default: add_entry($urandom_range(0, MAX_NODES - 1), $urandom_range(n, MAX_NODES - 1),
                           sel_value(), 0);
      endcase
    end
    // now and then the last marker is left off so the matrix carries into the next graph
    if ($urandom_range(0, 9) != 0) begin
      row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      add_entry(row, $urandom_range(0, 63), $urandom_range(0, 65535), 1);
    end
  endtask

  // entry driver
  always @(negedge clk) begin : drive_entries
    action_t a;
    logic push_n, we_n;
    push_n = push;
    we_n = 1'b0;
    if ($urandom_range(0, 199) == 0) in_burst = ~in_burst;
    if (!rst && !(push && !entry_taken)) begin
      push_n = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (quiescing) begin
        if (walk_results_q.size() == 0) begin
          if (settle == 0) quiescing = 0;
          else settle--;
        end
      end else if (pending_actions.size() > 0) begin
        a = pending_actions.pop_front();
        case (a.kind)
          ACT_ENTRY: begin
            push_n = 1'b1;
            row_index <= a.row;
            col_index <= a.col;
            edge_value <= a.value;
            last_entry <= a.last;
            send_gap = pick_gap(in_burst);
          end
          ACT_NODE_COUNT: begin
            we_n = 1'b1;
            cfg_wdata <= a.count;
          end
          default: begin
            quiescing = 1;
            settle = SETTLE_CYCLES;
          end
        endcase
      end
    end
    push <= push_n;
    cfg_we <= we_n;
  end

  // result-side stalls
  always @(negedge clk) begin : drive_pop
    if ($urandom_range(0, 199) == 0) out_burst = ~out_burst;
    if (out_stall > 0) begin
      out_stall--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      out_stall = pick_gap(out_burst);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : watch
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end else begin
      entry_taken <= !rst && push && !full;
      if (rst) begin
        node_count_reg = NODE_COUNT_RESET;
        for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
      end else begin
        if (cfg_we) begin
          node_count_reg = cfg_wdata;
          settings_seen++;
        end
        if (push && !full) begin
          apply_entry(row_index, col_index, edge_value, last_entry);
          entries_taken++;
        end
        if (pop && !empty) begin
          results_seen++;
          if (walk_results_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("unexpected result transfer: node %0d length %0d cover %0d last %0d",
                       node_id, tour_length, covers_all, last_node);
          end else begin
            want = walk_results_q.pop_front();
            if ({node_id, tour_length, covers_all, last_node} !== want) begin
              mismatch_count++;
              if (mismatch_count <= 10)
                $display("mismatch: exp node %0d len %0d cover %0d last %0d, got %0d %0d %0d %0d",
                         want.node_id, want.tour_length, want.covers_all, want.last_node,
                         node_id, tour_length, covers_all, last_node);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    int cfg, pick;
    for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
    // reset count of 32: pair walk, cleared rewrite, threshold, ignored indexes
    add_entry(0, 1, 65535, 0);
    add_entry(1, 0, HALF_Q2_14 + 1, 0);
    add_entry(0, 2, HALF_Q2_14, 0);
    add_entry(2, 3, 65535, 0);
    add_entry(2, 3, 0, 0);
    add_entry(32, 4, 65535, 0);
    add_entry(4, 63, 65535, 0);
    add_entry(63, 63, 65535, 0);
    add_entry(3, 2, 16384, 1);
    add_node_count(2);
    add_entry(0, 1, HALF_Q2_14 + 1, 1);
    add_node_count(0);
    add_entry(0, 0, 65535, 1);
    add_node_count(127);
    add_entry(31, 31, 0, 1);
    add_node_count(4);
    add_entry(1, 5, 65535, 0);
    add_entry(0, 1, 65535, 0);
    add_entry(1, 2, 65535, 0);
    add_entry(2, 3, 65535, 0);
    add_entry(3, 0, 65535, 1);
    add_node_count(1);
    add_entry(1, 0, 40000, 1);
    loaded_entries = 0;
    while (loaded_entries < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) cfg = $urandom_range(0, 127);
      else if (pick < 5) cfg = ($urandom_range(0, 1) == 0) ? MAX_NODES : $urandom_range(33, 127);
      else cfg = $urandom_range(2, 8);
      add_node_count(cfg);
      repeat ($urandom_range(1, 4)) add_graph(active_nodes(LEN_W'(cfg)));
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_actions.size() != 0 || push || quiescing || walk_results_q.size() != 0);
    repeat (100) @(posedge clk);
    $display("sent %0d matrix entries under %0d node-count settings, checked %0d walk nodes",
             entries_taken, settings_seen, results_seen);
    if (walk_results_q.size() != 0)
      $display("%0d expected results never arrived", walk_results_q.size());
    if (mismatch_count == 0 && walk_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
